// ----- design/cae_pkg.sv -----
// package for the callsign address encoder
// holds the callsign length, character codes, address constants and the ssid parser phase type
// no dependencies
`default_nettype none

package cae_pkg;

	localparam int CALL_LEN = 6;
	localparam int CNT_W    = $clog2(CALL_LEN + 1);
	localparam int IDX_W    = (CALL_LEN > 1) ? $clog2(CALL_LEN) : 1;
	localparam int ADDR_W   = 56;
	localparam int WIDE_W   = 64;

	localparam logic [7:0] CHAR_STAR  = 8'h2A;
	localparam logic [7:0] CHAR_DASH  = 8'h2D;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_LOW_A = 8'h61;
	localparam logic [7:0] CHAR_LOW_Z = 8'h7A;
	localparam logic [7:0] CASE_DIFF  = 8'h20;
	localparam logic [7:0] PAD_BYTE   = 8'h40;
	localparam logic [7:0] SSID_BASE  = 8'h60;
	localparam logic [4:0] SSID_MAX   = 5'd15;
	localparam logic [4:0] VALUE_SAT  = 5'd16;

	typedef enum logic [1:0] {
		PH_SKIP   = 2'd0,
		PH_DIGITS = 2'd1,
		PH_DONE   = 2'd2
	} num_phase_t;

endpackage

`default_nettype wire

// ----- design/callsign_address_encoder.sv -----
// callsign address encoder top level: input register, per-character parser, result register
// depends on cae_pkg
`default_nettype none

// Takes one callsign character per request on the slave side and, on the
// request marked by tlast, returns one 7-byte link-layer address plus an
// error flag on the master side. A character is registered on acceptance and
// folded into the parser state; a result passes the input register and then
// the result register before it is offered. One character per cycle is taken
// sustained, save that a last character stalls while an earlier result waits
// for the sink: the parser update and address assembly are a single shallow
// combinational step between the input register and the result register, and
// non-last characters still go in while that result waits. The parser state
// clears itself after every result; no clearing pass is needed after reset.
module callsign_address_encoder
	import cae_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] ch
	input  wire logic        s_tlast,   // last
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [55:0]      m_tdata,   // [55:0] address
	output logic             m_tuser    // [0] error
);

	// input register
	logic             valid_s1;
	logic [7:0]       ch_s1;
	logic             last_s1;

	// parser state
	logic [7:0]       call_bytes_q [CALL_LEN];
	logic [CNT_W-1:0] call_count_q;
	logic             seen_dash_q;
	logic             seen_star_q;
	logic             too_long_q;
	num_phase_t       phase_q;
	logic             negative_q;
	logic [4:0]       value_q;

	// result register
	logic              out_valid_q;
	logic [ADDR_W-1:0] address_q;
	logic              error_q;

	logic             adv_s1;
	logic             out_free;

	// next-state values
	logic [CNT_W-1:0] count_d;
	logic             dash_d;
	logic             star_d;
	logic             long_d;
	num_phase_t       phase_d;
	logic             neg_d;
	logic [4:0]       value_d;
	logic             wr_en;
	logic [7:0]       wr_data;
	logic             term;
	logic             is_white;
	logic             is_digit;
	logic [7:0]       upper;
	logic [7:0]       mac;
	logic [7:0]       sum10;
	logic             empty;
	logic             bad_ssid;
	logic             err;
	logic [4:0]       ssid;
	logic [WIDE_W-1:0] wide;

	assign out_free = !out_valid_q || m_tready;
	assign adv_s1   = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || adv_s1;

	always_comb begin
		term     = last_s1 && (ch_s1 == 8'h00);
		is_white = (ch_s1 == CHAR_SPACE) || (ch_s1 >= CHAR_TAB && ch_s1 <= CHAR_CR);
		is_digit = (ch_s1 >= CHAR_ZERO) && (ch_s1 <= CHAR_NINE);
		upper    = (ch_s1 >= CHAR_LOW_A && ch_s1 <= CHAR_LOW_Z) ? ch_s1 - CASE_DIFF : ch_s1;
		wr_data  = {upper[6:0], 1'b0};
		mac      = {value_q, 3'b000} + {2'b00, value_q, 1'b0};
		sum10    = mac + (ch_s1 - CHAR_ZERO);

		count_d = call_count_q;
		dash_d  = seen_dash_q;
		star_d  = seen_star_q;
		long_d  = too_long_q;
		phase_d = phase_q;
		neg_d   = negative_q;
		value_d = value_q;
		wr_en   = 1'b0;

		if (!term) begin
			if (ch_s1 == CHAR_STAR) begin
				star_d = 1'b1;
			end
			if (seen_dash_q) begin
				// integer-style ssid reader
				if (phase_q == PH_SKIP && is_white) begin
					phase_d = PH_SKIP;
				end else if (phase_q == PH_SKIP && (ch_s1 == CHAR_PLUS || ch_s1 == CHAR_DASH)) begin
					neg_d   = (ch_s1 == CHAR_DASH);
					phase_d = PH_DIGITS;
				end else if (phase_q == PH_SKIP || phase_q == PH_DIGITS) begin
					if (is_digit) begin
						phase_d = PH_DIGITS;
						value_d = (sum10 > {3'b000, VALUE_SAT}) ? VALUE_SAT : sum10[4:0];
					end else begin
						phase_d = PH_DONE;
					end
				end
			end else if (ch_s1 == CHAR_DASH) begin
				dash_d = 1'b1;
			end else if (call_count_q < CNT_W'(CALL_LEN)) begin
				wr_en   = 1'b1;
				count_d = call_count_q + 1'b1;
			end else begin
				long_d = 1'b1;
			end
		end

		empty    = term && (call_count_q == '0) && !seen_dash_q && !seen_star_q && !too_long_q;
		bad_ssid = dash_d && ((neg_d && value_d != 5'd0) || (value_d > SSID_MAX));
		ssid     = (dash_d && !bad_ssid) ? value_d : 5'd0;
		err      = empty || star_d || long_d || bad_ssid;

		wide = '0;
		for (int i = 0; i < CALL_LEN; i++) begin
			if (CNT_W'(i) < call_count_q) begin
				wide[(CALL_LEN - i) * 8 +: 8] = call_bytes_q[i];
			end else if (wr_en && CNT_W'(i) == call_count_q) begin
				wide[(CALL_LEN - i) * 8 +: 8] = wr_data;
			end else begin
				wide[(CALL_LEN - i) * 8 +: 8] = PAD_BYTE;
			end
		end
		wide[7:0] = SSID_BASE | {2'b00, ssid, 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ch_s1   <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && wr_en) begin
			call_bytes_q[call_count_q[IDX_W-1:0]] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			call_count_q <= '0;
			seen_dash_q  <= 1'b0;
			seen_star_q  <= 1'b0;
			too_long_q   <= 1'b0;
			phase_q      <= PH_SKIP;
			negative_q   <= 1'b0;
			value_q      <= 5'd0;
		end else if (adv_s1) begin
			if (last_s1) begin
				// state returns to its reset values after every result
				call_count_q <= '0;
				seen_dash_q  <= 1'b0;
				seen_star_q  <= 1'b0;
				too_long_q   <= 1'b0;
				phase_q      <= PH_SKIP;
				negative_q   <= 1'b0;
				value_q      <= 5'd0;
			end else begin
				call_count_q <= count_d;
				seen_dash_q  <= dash_d;
				seen_star_q  <= star_d;
				too_long_q   <= long_d;
				phase_q      <= phase_d;
				negative_q   <= neg_d;
				value_q      <= value_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && adv_s1 && last_s1) begin
			address_q <= err ? '0 : wide[ADDR_W-1:0];
			error_q   <= err;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = address_q;
	assign m_tuser  = error_q;

	// a result never goes out without a closing character behind it
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(valid_s1 && last_s1))
		else $error("result without closing character");

	// a rejected text reports an all-zero address
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("error result with nonzero address");

	// parser state is clear after a result is formed
	assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && last_s1 |=> call_count_q == '0 && !seen_dash_q && !seen_star_q && !too_long_q)
		else $error("parser state not cleared after result");

	// callsign count never passes the callsign length
	assert property (@(posedge clk) disable iff (!arst_n)
		call_count_q <= CNT_W'(CALL_LEN))
		else $error("callsign count overflow");

	// the ssid value stays within its saturation limit
	assert property (@(posedge clk) disable iff (!arst_n)
		value_q <= VALUE_SAT)
		else $error("ssid value beyond saturation");

endmodule

`default_nettype wire

// ----- tb/callsign_address_encoder_tb.sv -----
// self-checking testbench for callsign_address_encoder: directed callsign texts, then random ones
// depends on cae_pkg and the callsign_address_encoder rtl
`default_nettype none

module callsign_address_encoder_tb;
	import cae_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_CHARS = 1900;

	localparam logic [7:0] CHAR_NUL  = 8'h00;
	localparam logic [7:0] CHAR_LF   = 8'h0A;
	localparam logic [7:0] CHAR_UP_A = 8'h41;

	typedef logic [7:0] text_t [$];

	typedef struct {
		logic [7:0] ch;
		logic       last;
		bit         hold;   // wait for every pending address before sending
	} char_req_t;

	typedef struct {
		logic [55:0] address;
		logic        error;
	} addr_result_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic        m_tuser;

	char_req_t    char_queue[$];
	addr_result_t expected_addrs[$];

	// predictor state
	logic [7:0]       call_buf [CALL_LEN];
	logic [CNT_W-1:0] call_cnt  = '0;
	bit               dash_seen = 1'b0;
	bit               star_seen = 1'b0;
	bit               overflow  = 1'b0;
	num_phase_t       num_ph    = PH_SKIP;
	bit               num_neg   = 1'b0;
	logic [4:0]       num_val   = '0;

	int  queued_chars = 0;
	int  sent_texts   = 0;
	int  checked      = 0;
	int  rejected     = 0;
	int  mismatches   = 0;
	int  cycles       = 0;
	int  src_gap      = 0;
	int  src_calm     = 0;
	int  sink_gap     = 0;
	int  sink_calm    = 0;
	bit  hold_next    = 1'b0;

	callsign_address_encoder u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// mostly short gaps, a few long ones, and now and then a calm stretch with none
	function automatic int idle_len(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			calm = $urandom_range(50, 200);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic logic [7:0] call_char();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return CHAR_UP_A + 8'($urandom_range(0, 25));
		if (r < 8)
			return CHAR_LOW_A + 8'($urandom_range(0, 25));
		return CHAR_ZERO + 8'($urandom_range(0, 9));
	endfunction

	// fold one accepted character into the parser copy; a last item yields an address
	task automatic encode_char(input logic [7:0] c, input logic fin);
		bit           term, empty, bad, err;
		logic [4:0]   ssid;
		logic [55:0]  addr;
		logic [7:0]   u, b;
		int           v;
		addr_result_t r;
		term = fin && (c == CHAR_NUL);
		if (!term) begin
			if (c == CHAR_STAR)
				star_seen = 1'b1;
			if (dash_seen) begin
				if (num_ph == PH_SKIP) begin
					if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) begin
						// leading white space is skipped
					end else if (c == CHAR_PLUS || c == CHAR_DASH) begin
						num_neg = (c == CHAR_DASH);
						num_ph = PH_DIGITS;
					end else begin
						num_ph = PH_DIGITS;
						if (c >= CHAR_ZERO && c <= CHAR_NINE)
							num_val = 5'(int'(c) - int'(CHAR_ZERO));
						else
							num_ph = PH_DONE;
					end
				end else if (num_ph == PH_DIGITS) begin
					if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
						v = int'(num_val) * 10 + int'(c) - int'(CHAR_ZERO);
						num_val = (v > int'(VALUE_SAT)) ? VALUE_SAT : 5'(v);
					end else begin
						num_ph = PH_DONE;
					end
				end
			end else if (c == CHAR_DASH) begin
				dash_seen = 1'b1;
			end else if (call_cnt < CALL_LEN) begin
				u = (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) ? c - CASE_DIFF : c;
				call_buf[call_cnt] = u << 1;
				call_cnt++;
			end else begin
				overflow = 1'b1;
			end
		end
		if (fin) begin
			empty = term && call_cnt == 0 && !dash_seen && !star_seen && !overflow;
			bad = 1'b0;
			ssid = '0;
			if (dash_seen) begin
				if (num_neg && num_val != 0)
					bad = 1'b1;
				else if (num_val > SSID_MAX)
					bad = 1'b1;
				else
					ssid = num_val;
			end
			err = empty || star_seen || overflow || bad;
			addr = '0;
			if (!err) begin
				for (int i = 0; i < CALL_LEN; i++) begin
					b = (i < int'(call_cnt)) ? call_buf[i] : PAD_BYTE;
					addr = {addr[47:0], b};
				end
				addr = {addr[47:0], SSID_BASE | {3'b000, ssid[3:0], 1'b0}};
			end
			r.address = addr;
			r.error = err;
			expected_addrs.push_back(r);
			call_cnt = '0;
			dash_seen = 1'b0;
			star_seen = 1'b0;
			overflow = 1'b0;
			num_ph = PH_SKIP;
			num_neg = 1'b0;
			num_val = '0;
		end
	endtask

	// queue a text; last goes on its final byte, or on an added nul when asked
	task automatic send_text(input text_t t, input bit nul_end);
		char_req_t q;
		for (int i = 0; i < t.size(); i++) begin
			q.ch = t[i];
			q.last = !nul_end && (i == t.size() - 1);
			q.hold = hold_next;
			hold_next = 1'b0;
			char_queue.push_back(q);
			queued_chars++;
		end
		if (nul_end) begin
			q.ch = CHAR_NUL;
			q.last = 1'b1;
			q.hold = hold_next;
			hold_next = 1'b0;
			char_queue.push_back(q);
			queued_chars++;
		end
		sent_texts++;
	endtask

	task automatic send_str(input string s, input bit nul_end);
		text_t t;
		for (int i = 0; i < s.len(); i++)
			t.push_back(s[i]);
		send_text(t, nul_end);
	endtask

	// request driver
	always @(posedge clk) begin : drive
		bit fire;
		if (arst_n) begin
			fire = s_tvalid;
			if (s_tvalid && s_tready) begin
				encode_char(s_tdata, s_tlast);
				fire = 1'b0;
				src_gap = idle_len(src_calm);
			end
			if (!fire) begin
				if (src_gap > 0) begin
					src_gap--;
				end else if (char_queue.size() > 0 &&
						!(char_queue[0].hold && expected_addrs.size() > 0)) begin
					s_tdata <= char_queue[0].ch;
					s_tlast <= char_queue[0].last;
					fire = 1'b1;
					void'(char_queue.pop_front());
				end
			end
			s_tvalid <= fire;
		end
	end

	// result monitor and sink stalls
	always @(posedge clk) begin : collect
		addr_result_t want;
		bit           took;
		if (arst_n) begin
			took = m_tvalid && m_tready;
			if (took) begin
				if (expected_addrs.size() == 0) begin
					if (mismatches < 10)
						$display("address with none expected: %014h error %0b", m_tdata, m_tuser);
					mismatches++;
				end else begin
					want = expected_addrs.pop_front();
					checked++;
					if (want.error)
						rejected++;
					if (m_tdata !== want.address || m_tuser !== want.error) begin
						if (mismatches < 10)
							$display("mismatch on address %0d: expected %014h error %0b, got %014h error %0b",
								checked, want.address, want.error, m_tdata, m_tuser);
						mismatches++;
					end
				end
				sink_gap = idle_len(sink_calm);
			end else if (sink_gap == 0 && $urandom_range(0, 19) == 0) begin
				sink_gap = idle_len(sink_calm);
			end
			if (sink_gap > 0) begin
				sink_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		text_t t;
		int    kind, n, v, texts;
		string digits;
		bit    nul_end;

		// directed texts
		send_str("", 1'b1);
		send_str("a", 1'b0);
		send_str("CALL-7", 1'b0);
		send_str("abcdef-15", 1'b0);
		send_str("ABCDEFG", 1'b0);
		send_str("AB*", 1'b0);
		send_str("AB-16", 1'b0);
		send_str("AB- +3x", 1'b0);
		send_str("AB--1", 1'b0);
		send_str("AB--0", 1'b0);
		send_str("AB-", 1'b0);
		send_str("-", 1'b0);
		send_str("AB-999", 1'b0);
		send_str("AB-3*", 1'b0);
		send_str("Q-5", 1'b1);
		send_str("AB-0", 1'b0);
		t = '{8'hFF, 8'h80, 8'h7B, 8'h60, 8'h7A, 8'h40};
		send_text(t, 1'b0);
		t = '{CHAR_NUL, CHAR_UP_A};
		send_text(t, 1'b0);
		t = '{CHAR_UP_A, CHAR_DASH, CHAR_TAB, CHAR_LF, CHAR_CR, CHAR_SPACE, 8'h37};
		send_text(t, 1'b0);
		t = '{CHAR_UP_A, CHAR_DASH, 8'h31, CHAR_NUL, 8'h32};
		send_text(t, 1'b0);

		// random texts: mostly well-formed, some broken, some noise
		texts = 0;
		hold_next = 1'b1;
		while (queued_chars < RANDOM_CHARS) begin
			if (texts % 250 == 249)
				hold_next = 1'b1;
			texts++;
			t.delete();
			kind = $urandom_range(0, 99);
			nul_end = ($urandom_range(0, 99) < 15);
			if (kind < 85) begin
				n = $urandom_range(1, CALL_LEN);
				if (kind >= 70 && kind < 74)
					n = $urandom_range(CALL_LEN + 1, CALL_LEN + 3);
				repeat (n)
					t.push_back(call_char());
				if ($urandom_range(0, 3) != 0 || kind >= 74) begin
					t.push_back(CHAR_DASH);
					if ($urandom_range(0, 4) == 0)
						repeat ($urandom_range(1, 2))
							t.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
					v = $urandom_range(0, 19);
					if (v == 0)
						t.push_back(CHAR_PLUS);
					else if (v == 1)
						t.push_back(CHAR_DASH);
					v = $urandom_range(0, 15);
					if (kind >= 74 && kind < 78)
						v = $urandom_range(16, 999);
					else if (kind >= 78 && kind < 81) begin
						t.push_back(CHAR_DASH);
						v = $urandom_range(0, 20);
					end
					if ($urandom_range(0, 9) == 0)
						t.push_back(CHAR_ZERO);
					digits = $sformatf("%0d", v);
					for (int i = 0; i < digits.len(); i++)
						t.push_back(digits[i]);
					if ($urandom_range(0, 9) == 0)
						t.push_back(call_char());
				end
				if (kind >= 81)
					t.insert($urandom_range(0, t.size()), CHAR_STAR);
			end else begin
				repeat ($urandom_range(1, 8))
					t.push_back(8'($urandom_range(0, 255)));
			end
			send_text(t, nul_end);
		end

		while (char_queue.size() > 0 || s_tvalid)
			@(posedge clk);
		while (expected_addrs.size() > 0)
			@(posedge clk);
		repeat (10)
			@(posedge clk);

		$display("sent %0d callsign texts in %0d characters", sent_texts, queued_chars);
		$display("checked %0d addresses, %0d of them rejected, %0d mismatches",
			checked, rejected, mismatches);
		if (mismatches == 0 && expected_addrs.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
	end

endmodule

`default_nettype wire

// ----- callsign_address_encoder.f -----
design/cae_pkg.sv
design/callsign_address_encoder.sv
tb/callsign_address_encoder_tb.sv
